FILE: rtl/tnb_pkg.sv
package tnb_pkg;

	// Field formats.
	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORM_W           = 16;

	// Edge vectors and cross product.
	localparam int E_W  = COORD_BITS + 1;
	localparam int P_W  = 2 * E_W;
	localparam int CM_W = P_W + 1;

	// Shared serial multiplier and the prescale limit on cross-product magnitudes.
	localparam int PRE_BITS = 31;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int M2_W     = 2 * PRE_BITS;
	localparam int S_W      = PROD_W;

	// Divider and square root.
	localparam int NUM_W = M2_W + 2 * NORMAL_FRAC_BITS;
	localparam int Q_W   = 2 * NORMAL_FRAC_BITS + 1;
	localparam int RAD_W = 2 * NORMAL_FRAC_BITS + 2;
	localparam int ROOT_W = NORMAL_FRAC_BITS + 1;
	localparam int REM_W  = NORMAL_FRAC_BITS + 4;
	localparam int NX_W   = NORMAL_FRAC_BITS + NORM_W + 2;

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_MIN    = 2'd1,
		KIND_MAX    = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic signed [COORD_BITS-1:0] a_z;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic signed [COORD_BITS-1:0] b_z;
		logic signed [COORD_BITS-1:0] c_x;
		logic signed [COORD_BITS-1:0] c_y;
		logic signed [COORD_BITS-1:0] c_z;
		logic                         final_tri;
	} tri_t;

	typedef struct packed {
		kind_t                        kind;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic signed [NORM_W-1:0]     norm_x;
		logic signed [NORM_W-1:0]     norm_y;
		logic signed [NORM_W-1:0]     norm_z;
		logic                         run_end;
	} res_t;

endpackage

FILE: rtl/tnb_mul.sv
module tnb_mul import tnb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [PROD_W-1:0] a_q;
	logic [MUL_W-1:0]  b_q;
	logic [PROD_W-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	// Control: one multiplier bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-and-add datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: rtl/tnb_div.sv
module tnb_div import tnb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [M2_W-1:0] num,
	input  logic [S_W-1:0]  den,
	output logic            done,
	output logic [Q_W-1:0]  quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [S_W-1:0]   den_q;
	logic [S_W:0]     rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [S_W:0]     rem_sh;
	logic             ge;

	// Bring down one numerator bit and try the subtraction.
	always_comb begin
		rem_sh = {rem_q[S_W-1:0], num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {num, {(2 * NORMAL_FRAC_BITS){1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/tnb_sqrt.sv
module tnb_sqrt import tnb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [Q_W-1:0]    rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// Bring down two radicand bits and test the next root bit.
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial  = REM_W'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Digit-by-digit integer square root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/triangle_normal_and_bounds_top.sv
// Takes one triangle per word (three Q12.12 vertices and a last-triangle flag) and returns
// three vertex words carrying the unit face normal in Q1.14, truncated toward zero, followed
// by the minimum and maximum corner words when the triangle is marked last. The work goes to
// six cross-product terms and three squares on a bit-serial 32-bit multiplier, one-bit
// prescale shifts, and, per normal component, a bit-serial restoring division and a square
// root, besides the accept, cross and sum steps and the output words. A degenerate
// triangle skips the division and the square root. A new triangle is taken once the
// previous one's words have all entered the output register; the last word may still be
// waiting there. Output stalls add their cycles to the emit phase.
module triangle_normal_and_bounds_top import tnb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tri_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_word
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_MUL      = 13'b0000000000010,
		S_MWAIT    = 13'b0000000000100,
		S_CROSS    = 13'b0000000001000,
		S_PRE      = 13'b0000000010000,
		S_SQ       = 13'b0000000100000,
		S_SQWAIT   = 13'b0000001000000,
		S_SUM      = 13'b0000010000000,
		S_DIV      = 13'b0000100000000,
		S_DIVWAIT  = 13'b0001000000000,
		S_SQRT     = 13'b0010000000000,
		S_SQRTWAIT = 13'b0100000000000,
		S_EMIT     = 13'b1000000000000
	} state_t;

	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	state_t state_q;
	tri_t   tri_q;

	logic signed [E_W-1:0]    e_q [6];
	logic signed [P_W-1:0]    p_q [6];
	logic                     psign_q;
	logic [2:0]               pidx_q;
	logic [1:0]               cidx_q;
	logic [2:0]               widx_q;
	logic [CM_W-1:0]          m_q [3];
	logic                     sign_q [3];
	logic [PROD_W-1:0]        m2_q [3];
	logic [S_W-1:0]           s_q;
	logic signed [NORM_W-1:0] n_q [3];

	logic signed [COORD_BITS-1:0] low_x_q, low_y_q, low_z_q;
	logic signed [COORD_BITS-1:0] high_x_q, high_y_q, high_z_q;

	res_t out_q;
	logic out_valid_q;

	logic signed [E_W-1:0] opa, opb;
	logic [E_W-1:0]        maga, magb;
	logic                  mul_start;
	logic [MUL_W-1:0]      mul_a, mul_b;
	logic                  mul_done;
	logic [PROD_W-1:0]     mul_prod;
	logic                  div_done;
	logic [Q_W-1:0]        div_quo;
	logic                  sqrt_done;
	logic [ROOT_W-1:0]     sqrt_root;
	logic signed [CM_W-1:0] c [3];
	logic                  pre_big;
	logic signed [P_W-1:0] pmag;
	logic signed [NX_W-1:0] nx;
	logic                  out_free;
	logic                  load;
	logic                  last_word;
	logic signed [COORD_BITS-1:0] vx, vy, vz;

	// Operand pairs of the six cross-product terms.
	always_comb begin
		unique case (pidx_q)
			3'd0:    begin opa = e_q[1]; opb = e_q[5]; end
			3'd1:    begin opa = e_q[2]; opb = e_q[4]; end
			3'd2:    begin opa = e_q[2]; opb = e_q[3]; end
			3'd3:    begin opa = e_q[0]; opb = e_q[5]; end
			3'd4:    begin opa = e_q[0]; opb = e_q[4]; end
			3'd5:    begin opa = e_q[1]; opb = e_q[3]; end
			default: begin opa = '0; opb = '0; end
		endcase
		maga = opa[E_W-1] ? E_W'(-opa) : E_W'(opa);
		magb = opb[E_W-1] ? E_W'(-opb) : E_W'(opb);
	end

	// The multiplier serves both the cross product and the squares.
	always_comb begin
		mul_start = (state_q == S_MUL) || (state_q == S_SQ);
		if (state_q == S_SQ) begin
			mul_a = m_q[cidx_q][MUL_W-1:0];
			mul_b = m_q[cidx_q][MUL_W-1:0];
		end else begin
			mul_a = MUL_W'(maga);
			mul_b = MUL_W'(magb);
		end
	end

	tnb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tnb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIV),
		.num    (m2_q[cidx_q][M2_W-1:0]),
		.den    (s_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	tnb_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQRT),
		.rad    (div_quo),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// Cross product, prescale test, signed product and signed normal.
	always_comb begin
		c[0]    = CM_W'(p_q[0]) - CM_W'(p_q[1]);
		c[1]    = CM_W'(p_q[2]) - CM_W'(p_q[3]);
		c[2]    = CM_W'(p_q[4]) - CM_W'(p_q[5]);
		pre_big = (|m_q[0][CM_W-1:PRE_BITS]) || (|m_q[1][CM_W-1:PRE_BITS]) ||
		          (|m_q[2][CM_W-1:PRE_BITS]);
		pmag    = P_W'(mul_prod);
		nx      = NX_W'(sqrt_root);
		if (sign_q[cidx_q]) begin
			nx = -nx;
		end
	end

	// Output word selection.
	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		load      = (state_q == S_EMIT) && out_free;
		last_word = tri_q.final_tri ? (widx_q == 3'd4) : (widx_q == 3'd2);
		unique case (widx_q)
			3'd0:    begin vx = tri_q.a_x; vy = tri_q.a_y; vz = tri_q.a_z; end
			3'd1:    begin vx = tri_q.b_x; vy = tri_q.b_y; vz = tri_q.b_z; end
			default: begin vx = tri_q.c_x; vy = tri_q.c_y; vz = tri_q.c_z; end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pidx_q  <= '0;
			cidx_q  <= '0;
			widx_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						pidx_q  <= '0;
					end
				end
				S_MUL: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						if (pidx_q == 3'd5) begin
							state_q <= S_CROSS;
						end else begin
							pidx_q  <= pidx_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_CROSS: state_q <= S_PRE;
				S_PRE: begin
					if (!pre_big) begin
						state_q <= S_SQ;
						cidx_q  <= '0;
					end
				end
				S_SQ: state_q <= S_SQWAIT;
				S_SQWAIT: begin
					if (mul_done) begin
						if (cidx_q == 2'd2) begin
							state_q <= S_SUM;
						end else begin
							cidx_q  <= cidx_q + 1'b1;
							state_q <= S_SQ;
						end
					end
				end
				S_SUM: begin
					cidx_q <= '0;
					widx_q <= '0;
					if (m2_q[0] + m2_q[1] + m2_q[2] == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: state_q <= S_SQRTWAIT;
				S_SQRTWAIT: begin
					if (sqrt_done) begin
						if (cidx_q == 2'd2) begin
							state_q <= S_EMIT;
						end else begin
							cidx_q  <= cidx_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						widx_q <= widx_q + 1'b1;
						if (last_word) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the normal computation.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			tri_q  <= in_word;
			e_q[0] <= E_W'(in_word.b_x) - E_W'(in_word.a_x);
			e_q[1] <= E_W'(in_word.b_y) - E_W'(in_word.a_y);
			e_q[2] <= E_W'(in_word.b_z) - E_W'(in_word.a_z);
			e_q[3] <= E_W'(in_word.c_x) - E_W'(in_word.a_x);
			e_q[4] <= E_W'(in_word.c_y) - E_W'(in_word.a_y);
			e_q[5] <= E_W'(in_word.c_z) - E_W'(in_word.a_z);
		end
		if (state_q == S_MUL) begin
			psign_q <= opa[E_W-1] ^ opb[E_W-1];
		end
		if (state_q == S_MWAIT && mul_done) begin
			p_q[pidx_q] <= psign_q ? -pmag : pmag;
		end
		if (state_q == S_CROSS) begin
			for (int i = 0; i < 3; i++) begin
				sign_q[i] <= c[i][CM_W-1];
				m_q[i]    <= c[i][CM_W-1] ? CM_W'(-c[i]) : CM_W'(c[i]);
			end
		end
		if (state_q == S_PRE && pre_big) begin
			for (int i = 0; i < 3; i++) begin
				m_q[i] <= m_q[i] >> 1;
			end
		end
		if (state_q == S_SQWAIT && mul_done) begin
			m2_q[cidx_q] <= mul_prod;
		end
		if (state_q == S_SUM) begin
			s_q <= m2_q[0] + m2_q[1] + m2_q[2];
			if (m2_q[0] + m2_q[1] + m2_q[2] == '0) begin
				for (int i = 0; i < 3; i++) begin
					n_q[i] <= '0;
				end
			end
		end
		if (state_q == S_SQRTWAIT && sqrt_done) begin
			n_q[cidx_q] <= nx[NORM_W-1:0];
		end
	end

	// Running bounds: updated as each vertex word leaves, cleared after the maximum corner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q  <= C_MAX;
			low_y_q  <= C_MAX;
			low_z_q  <= C_MAX;
			high_x_q <= C_MIN;
			high_y_q <= C_MIN;
			high_z_q <= C_MIN;
		end else if (load) begin
			if (widx_q == 3'd4) begin
				low_x_q  <= C_MAX;
				low_y_q  <= C_MAX;
				low_z_q  <= C_MAX;
				high_x_q <= C_MIN;
				high_y_q <= C_MIN;
				high_z_q <= C_MIN;
			end else if (widx_q < 3'd3) begin
				if (vx < low_x_q)  low_x_q  <= vx;
				if (vy < low_y_q)  low_y_q  <= vy;
				if (vz < low_z_q)  low_z_q  <= vz;
				if (vx > high_x_q) high_x_q <= vx;
				if (vy > high_y_q) high_y_q <= vy;
				if (vz > high_z_q) high_z_q <= vz;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.run_end <= last_word;
			if (widx_q < 3'd3) begin
				out_q.kind   <= KIND_VERTEX;
				out_q.pos_x  <= vx;
				out_q.pos_y  <= vy;
				out_q.pos_z  <= vz;
				out_q.norm_x <= n_q[0];
				out_q.norm_y <= n_q[1];
				out_q.norm_z <= n_q[2];
			end else begin
				out_q.kind   <= (widx_q == 3'd3) ? KIND_MIN : KIND_MAX;
				out_q.pos_x  <= (widx_q == 3'd3) ? low_x_q : high_x_q;
				out_q.pos_y  <= (widx_q == 3'd3) ? low_y_q : high_y_q;
				out_q.pos_z  <= (widx_q == 3'd3) ? low_z_q : high_z_q;
				out_q.norm_x <= '0;
				out_q.norm_y <= '0;
				out_q.norm_z <= '0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
